// File: sv/rational_arithmetic_unit_defines.svh
// ----------------------------------------------------------------------------
// rational arithmetic unit assertion macros
// shared concurrent assertion forms for the rational arithmetic unit
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RAU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define RAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// types, codes and constants shared by the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam int OPERAND_BITS_DEF = 16;
   localparam int RES_NUM_BITS     = 32;
   localparam int RES_DEN_BITS     = 31;
   localparam logic [RES_DEN_BITS-1:0] OUT_MAX = '1;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      MUL_T1  = 2'd0,
      MUL_T2  = 2'd1,
      MUL_DEN = 2'd2
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        combine;
      logic        gcd_init;
      logic        gcd_step;
      logic        div_init;
      logic        div_step;
      logic        finish;
   } cmd_type;

   typedef struct packed {
      logic err;
      logic num_zero;
      logic gcd_eq;
      logic div_last;
      logic out_full;
   } sts_type;

endpackage

// File: sv/rau_req_if.sv
// ----------------------------------------------------------------------------
// rau_req_if
// operand word channel: opcode and two fractions, valid/ready handshake
// ----------------------------------------------------------------------------
interface rau_req_if #(
   parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
);
   logic                           valid;
   logic                           ready;
   logic [1:0]                     opcode;
   logic signed [OPERAND_BITS-1:0] first_numerator;
   logic [OPERAND_BITS-2:0]        first_denominator;
   logic signed [OPERAND_BITS-1:0] second_numerator;
   logic [OPERAND_BITS-2:0]        second_denominator;

   modport source (
      output valid, opcode, first_numerator, first_denominator,
             second_numerator, second_denominator,
      input  ready
   );

   modport sink (
      input  valid, opcode, first_numerator, first_denominator,
             second_numerator, second_denominator,
      output ready
   );
endinterface

// File: sv/rau_rsp_if.sv
// ----------------------------------------------------------------------------
// rau_rsp_if
// result word channel: reduced fraction and status, valid/ready handshake
// ----------------------------------------------------------------------------
interface rau_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [rau_pkg::RES_NUM_BITS-1:0] result_numerator;
   logic [rau_pkg::RES_DEN_BITS-1:0]        result_denominator;
   logic                                    status;

   modport source (
      output valid, result_numerator, result_denominator, status,
      input  ready
   );

   modport sink (
      input  valid, result_numerator, result_denominator, status,
      output ready
   );
endinterface

// File: sv/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl
// sequencer: multiply steps, combine, binary gcd loop, exact division, output
// ----------------------------------------------------------------------------
module rau_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output rau_pkg::cmd_type cmd,
   input  rau_pkg::sts_type sts
);
   import rau_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_T1,
      S_MUL_T2,
      S_MUL_DEN,
      S_COMBINE,
      S_CHECK,
      S_GCD,
      S_DIV,
      S_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.mul_sel = MUL_T1;
      req_ready   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MUL_T1;
            end
         end
         S_MUL_T1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_T1;
            state_in    = S_MUL_T2;
         end
         S_MUL_T2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_T2;
            state_in    = S_MUL_DEN;
         end
         S_MUL_DEN: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_DEN;
            state_in    = S_COMBINE;
         end
         S_COMBINE: begin
            cmd.combine = 1'b1;
            state_in    = S_CHECK;
         end
         S_CHECK: begin
            if (sts.err || sts.num_zero) begin
               state_in = S_FINISH;
            end else begin
               cmd.gcd_init = 1'b1;
               state_in     = S_GCD;
            end
         end
         S_GCD: begin
            if (sts.gcd_eq) begin
               cmd.div_init = 1'b1;
               state_in     = S_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!sts.out_full) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: sv/rau_dpath.sv
// ----------------------------------------------------------------------------
// rau_dpath
// operand registers, shared multiplier, binary gcd, dual exact divider, output
// ----------------------------------------------------------------------------
`include "rational_arithmetic_unit_defines.svh"

module rau_dpath #(
   parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  rau_pkg::cmd_type                        cmd,
   output rau_pkg::sts_type                        sts,
   input  logic [1:0]                              req_opcode,
   input  logic signed [OPERAND_BITS-1:0]          req_first_numerator,
   input  logic [OPERAND_BITS-2:0]                 req_first_denominator,
   input  logic signed [OPERAND_BITS-1:0]          req_second_numerator,
   input  logic [OPERAND_BITS-2:0]                 req_second_denominator,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [rau_pkg::RES_NUM_BITS-1:0] rsp_result_numerator,
   output logic [rau_pkg::RES_DEN_BITS-1:0]        rsp_result_denominator,
   output logic                                    rsp_status
);
   import rau_pkg::*;

   localparam int MB = OPERAND_BITS;
   localparam int DB = OPERAND_BITS - 1;
   localparam int PB = 2 * OPERAND_BITS;
   localparam int WB = 2 * OPERAND_BITS + 1;
   localparam int CB = $clog2(WB);
   localparam int KB = $clog2(WB + 1);
   localparam int XB = (WB > RES_NUM_BITS) ? WB : RES_NUM_BITS;

   // operand registers
   opcode_type    op_ff;
   logic [MB-1:0] m1_ff, m2_ff;
   logic          s1_ff, s2_ff;
   logic [DB-1:0] d1_ff, d2_ff;
   logic          err_ff;
   logic [MB-1:0] raw1, raw2, mag1, mag2;

   // products and combined fraction
   logic [PB-1:0] t1_ff, t2_ff, dp_ff;
   logic [MB-1:0] mul_a, mul_b;
   logic [PB-1:0] prod;
   logic [WB-1:0] nmag_ff, nmag_in, den_ff;
   logic          neg_ff, neg_in;

   // gcd and divider
   logic [WB-1:0] ga_ff, ga_in, gb_ff, gb_in, g_ff;
   logic [KB-1:0] gk_ff, gk_in;
   logic [WB-1:0] nq_ff, nr_ff, dq_ff, dr_ff;
   logic [WB-1:0] nq_in, nr_in, dq_in, dr_in;
   logic [WB:0]   ntrial, dtrial, gext;
   logic [CB-1:0] cnt_ff;

   // output stage
   logic                           rsp_valid_ff;
   logic signed [RES_NUM_BITS-1:0] res_num_ff, res_num_in;
   logic [RES_DEN_BITS-1:0]        res_den_ff, res_den_in;
   logic                           res_st_ff;
   logic [XB-1:0]                  nq_x, dq_x;
   logic [RES_DEN_BITS-1:0]        nsat, dsat;

   // sign-magnitude split, the most negative code keeps its full magnitude
   assign raw1 = $unsigned(req_first_numerator);
   assign raw2 = $unsigned(req_second_numerator);
   assign mag1 = raw1[MB-1] ? (~raw1 + 1'b1) : raw1;
   assign mag2 = raw2[MB-1] ? (~raw2 + 1'b1) : raw2;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= opcode_type'(req_opcode);
         m1_ff  <= mag1;
         m2_ff  <= mag2;
         s1_ff  <= raw1[MB-1];
         s2_ff  <= raw2[MB-1];
         d1_ff  <= req_first_denominator;
         d2_ff  <= req_second_denominator;
         err_ff <= (req_first_denominator == '0) || (req_second_denominator == '0)
                   || ((opcode_type'(req_opcode) == OP_DIV) && (raw2 == '0));
      end
   end

   // shared multiplier operand select
   always_comb begin
      case (cmd.mul_sel)
         MUL_T1: begin
            mul_a = m1_ff;
            mul_b = (op_ff == OP_MUL) ? m2_ff : {1'b0, d2_ff};
         end
         MUL_T2: begin
            mul_a = m2_ff;
            mul_b = {1'b0, d1_ff};
         end
         MUL_DEN: begin
            mul_a = {1'b0, d1_ff};
            mul_b = (op_ff == OP_DIV) ? m2_ff : {1'b0, d2_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = PB'(mul_a) * PB'(mul_b);

   always_ff @(posedge clock) begin
      if (cmd.mul_en && (cmd.mul_sel == MUL_T1)) t1_ff <= prod;
      if (cmd.mul_en && (cmd.mul_sel == MUL_T2)) t2_ff <= prod;
      if (cmd.mul_en && (cmd.mul_sel == MUL_DEN)) dp_ff <= prod;
   end

   // signed add or subtract of the cross products; multiply and divide pass the first product
   always_comb begin
      logic n1, n2;
      logic [WB-1:0] t1w, t2w;
      t1w = {1'b0, t1_ff};
      t2w = {1'b0, t2_ff};
      n1  = s1_ff && (t1_ff != '0);
      n2  = ((op_ff == OP_SUB) ? !s2_ff : s2_ff) && (t2_ff != '0);
      if ((op_ff == OP_ADD) || (op_ff == OP_SUB)) begin
         if (n1 == n2) begin
            nmag_in = t1w + t2w;
            neg_in  = n1;
         end else if (t1w >= t2w) begin
            nmag_in = t1w - t2w;
            neg_in  = n1;
         end else begin
            nmag_in = t2w - t1w;
            neg_in  = n2;
         end
      end else begin
         nmag_in = t1w;
         neg_in  = s1_ff ^ s2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.combine) begin
         nmag_ff <= nmag_in;
         neg_ff  <= neg_in;
         den_ff  <= {1'b0, dp_ff};
      end
   end

   // binary gcd, one step per cycle
   always_comb begin
      ga_in = ga_ff;
      gb_in = gb_ff;
      gk_in = gk_ff;
      if (!ga_ff[0] && !gb_ff[0]) begin
         ga_in = ga_ff >> 1;
         gb_in = gb_ff >> 1;
         gk_in = gk_ff + 1'b1;
      end else if (!ga_ff[0]) begin
         ga_in = ga_ff >> 1;
      end else if (!gb_ff[0]) begin
         gb_in = gb_ff >> 1;
      end else if (ga_ff > gb_ff) begin
         ga_in = (ga_ff - gb_ff) >> 1;
      end else begin
         gb_in = (gb_ff - ga_ff) >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.gcd_init) begin
         ga_ff <= nmag_ff;
         gb_ff <= den_ff;
         gk_ff <= '0;
      end else if (cmd.gcd_step) begin
         ga_ff <= ga_in;
         gb_ff <= gb_in;
         gk_ff <= gk_in;
      end
   end

   // two restoring dividers sharing the gcd as divisor, one bit per cycle
   assign gext   = {1'b0, g_ff};
   assign ntrial = {nr_ff, nq_ff[WB-1]};
   assign dtrial = {dr_ff, dq_ff[WB-1]};

   always_comb begin
      logic [WB:0] ndiff, ddiff;
      ndiff = ntrial - gext;
      ddiff = dtrial - gext;
      if (ntrial >= gext) begin
         nr_in = ndiff[WB-1:0];
         nq_in = {nq_ff[WB-2:0], 1'b1};
      end else begin
         nr_in = ntrial[WB-1:0];
         nq_in = {nq_ff[WB-2:0], 1'b0};
      end
      if (dtrial >= gext) begin
         dr_in = ddiff[WB-1:0];
         dq_in = {dq_ff[WB-2:0], 1'b1};
      end else begin
         dr_in = dtrial[WB-1:0];
         dq_in = {dq_ff[WB-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         g_ff   <= ga_ff << gk_ff;
         nq_ff  <= nmag_ff;
         dq_ff  <= den_ff;
         nr_ff  <= '0;
         dr_ff  <= '0;
         cnt_ff <= CB'(WB - 1);
      end else if (cmd.div_step) begin
         nq_ff  <= nq_in;
         dq_ff  <= dq_in;
         nr_ff  <= nr_in;
         dr_ff  <= dr_in;
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   // saturate, apply sign, zero and error give 0/1
   assign nq_x = XB'(nq_ff);
   assign dq_x = XB'(dq_ff);
   assign nsat = (nq_x > XB'(OUT_MAX)) ? OUT_MAX : nq_x[RES_DEN_BITS-1:0];
   assign dsat = (dq_x > XB'(OUT_MAX)) ? OUT_MAX : dq_x[RES_DEN_BITS-1:0];

   always_comb begin
      if (err_ff || (nmag_ff == '0)) begin
         res_num_in = '0;
         res_den_in = RES_DEN_BITS'(1);
      end else begin
         res_num_in = neg_ff ? -$signed({1'b0, nsat}) : $signed({1'b0, nsat});
         res_den_in = dsat;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         res_num_ff <= res_num_in;
         res_den_ff <= res_den_in;
         res_st_ff  <= err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_result_numerator   = res_num_ff;
   assign rsp_result_denominator = res_den_ff;
   assign rsp_status             = res_st_ff;

   assign sts.err      = err_ff;
   assign sts.num_zero = (nmag_ff == '0);
   assign sts.gcd_eq   = (ga_ff == gb_ff);
   assign sts.div_last = (cnt_ff == '0);
   assign sts.out_full = rsp_valid_ff && !rsp_ready;

   `RAU_ASSERT_IMP(a_gcd_nonzero, clock, reset, cmd.gcd_step, (ga_ff != '0) && (gb_ff != '0), "gcd operand reached zero")
   `RAU_ASSERT_NEXT(a_finish_valid, clock, reset, cmd.finish, rsp_valid, "finish did not raise valid")
   `RAU_ASSERT_IMP(a_err_zero, clock, reset, rsp_valid && rsp_status, (rsp_result_numerator == '0) && (rsp_result_denominator == RES_DEN_BITS'(1)), "error word is not 0/1")
   `RAU_ASSERT_IMP(a_den_nonzero, clock, reset, rsp_valid, rsp_result_denominator != '0, "zero denominator in result")

endmodule

// File: sv/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// one word at a time: after a word is accepted the sequencer runs the multiply, combine,
//   gcd and divide phases, then writes the output register; zero or error words skip the
//   gcd and divide phases. a new word is taken only once the sequencer is back in idle;
//   the dividers work on W = 2*OPERAND_BITS+1 bits (33 at default)
// reset: synchronous active high, clears the sequencer and the result valid
// add, subtract, multiply or divide two fractions and reduce to lowest terms
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
   parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   rau_req_if.sink    req_bus,
   rau_rsp_if.source  rsp_bus
);
   import rau_pkg::*;

   // command and status between sequencer and datapath
   cmd_type cmd;
   sts_type sts;

   // sequencer: walks multiply, combine, gcd and divide phases for one word
   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // datapath: one shared multiplier, gcd loop, two dividers, output register
   // the output register lets a new word enter while a result waits
   rau_dpath #(
      .OPERAND_BITS (OPERAND_BITS)
   ) u_dpath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .sts                    (sts),
      .req_opcode             (req_bus.opcode),
      .req_first_numerator    (req_bus.first_numerator),
      .req_first_denominator  (req_bus.first_denominator),
      .req_second_numerator   (req_bus.second_numerator),
      .req_second_denominator (req_bus.second_denominator),
      .rsp_valid              (rsp_bus.valid),
      .rsp_ready              (rsp_bus.ready),
      .rsp_result_numerator   (rsp_bus.result_numerator),
      .rsp_result_denominator (rsp_bus.result_denominator),
      .rsp_status             (rsp_bus.status)
   );

endmodule
